// ----- hw/rtl/tmcw_pkg.sv -----
// Package for the text-mode console writer.
// Holds screen geometry, command codes and the command and result word types.
// No dependencies.
package tmcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  localparam int ROW_W = 5;
  localparam int COL_W = 7;
  localparam int OFF_W = 11;

  localparam logic [1:0] MODE_PUT       = 2'd0;
  localparam logic [1:0] MODE_NEWLINE   = 2'd1;
  localparam logic [1:0] MODE_BACKSPACE = 2'd2;
  localparam logic [1:0] MODE_CLEAR     = 2'd3;

  localparam logic [7:0]  BLANK_CHAR  = 8'h20;
  localparam logic [7:0]  RESET_COLOR = 8'h07;
  localparam logic [15:0] RESET_CELL  = 16'h0720;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] char_code;
  } cmd_t;

  typedef struct packed {
    logic [ROW_W-1:0] cursor_row;
    logic [COL_W-1:0] cursor_column;
    logic [OFF_W-1:0] cursor_offset;
    logic             wrote_cell;
    logic [OFF_W-1:0] written_offset;
    logic [15:0]      written_entry;
  } result_t;

endpackage

// ----- hw/rtl/text_mode_console_writer_top.sv -----
// Text-mode console writer: one screen memory of character/attribute cells
// plus the cursor logic. Depends on tmcw_pkg.
//
// Takes one command word when start is high and busy is low, and returns one
// result word per command, on result for the single cycle that done is high;
// the receiver cannot stall it, so it must take every done cycle. Put char,
// newline and backspace within a row give their result in the next cycle,
// with busy staying low. Backspace from column 0 to the row above reads
// that row one cell per cycle through the single memory read port, right
// to left. Clear screen writes every cell through the single write port,
// one per cycle. After reset the same clearing pass runs with busy high
// and gives no result. The text_color register may be written at any time
// (cfg_ready is always high) but should only change while no command is in
// progress.
module text_mode_console_writer_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  tmcw_pkg::cmd_t cmd,
  output logic           done,
  output tmcw_pkg::result_t result,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [7:0]     cfg_data
);
  import tmcw_pkg::*;

  localparam logic [COL_W-1:0] LAST_COL  = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(ROWS - 1);
  localparam logic [OFF_W-1:0] ROW_STEP  = OFF_W'(COLUMNS);
  localparam logic [OFF_W-1:0] LAST_CELL = OFF_W'(CELLS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SWEEP
  } state_t;

  state_t           state;
  logic [7:0]       text_color;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;
  logic [OFF_W-1:0] row_base;

  logic [OFF_W-1:0] sweep_addr;
  logic [15:0]      sweep_val;
  logic             sweep_report;

  logic [COL_W-1:0] scan_col;
  logic             scan_issue;
  logic             rd_pend;
  logic [COL_W-1:0] rd_col;
  logic [15:0]      rd_data;

  logic             wr_flag;
  logic [OFF_W-1:0] wr_off;
  logic [15:0]      wr_entry;

  logic [15:0]      screen [CELLS];

  logic             accept;
  logic             mem_we;
  logic [OFF_W-1:0] mem_wa;
  logic [15:0]      mem_wd;
  logic             mem_re;
  logic [OFF_W-1:0] mem_ra;
  logic [OFF_W-1:0] cur_off;
  logic [15:0]      blank;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign cur_off   = row_base + OFF_W'(col);
  assign blank     = {text_color, BLANK_CHAR};
  assign mem_re    = (state == S_SCAN) && scan_issue;
  assign mem_ra    = row_base + OFF_W'(scan_col);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = cur_off;
    mem_wd = {text_color, cmd.char_code};
    if (state == S_SWEEP) begin
      mem_we = 1'b1;
      mem_wa = sweep_addr;
      mem_wd = sweep_val;
    end else if (accept && cmd.mode == MODE_PUT) begin
      mem_we = 1'b1;
    end else if (accept && cmd.mode == MODE_BACKSPACE && col != '0) begin
      mem_we = 1'b1;
      mem_wa = cur_off - OFF_W'(1);
      mem_wd = blank;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      screen[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data <= screen[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= RESET_COLOR;
    end else if (cfg_valid && cfg_ready) begin
      text_color <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_SWEEP;
      row          <= '0;
      col          <= '0;
      row_base     <= '0;
      sweep_addr   <= '0;
      sweep_val    <= RESET_CELL;
      sweep_report <= 1'b0;
      scan_col     <= '0;
      scan_issue   <= 1'b0;
      rd_pend      <= 1'b0;
      rd_col       <= '0;
      done         <= 1'b0;
      wr_flag      <= 1'b0;
      wr_off       <= '0;
      wr_entry     <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            wr_flag  <= 1'b0;
            wr_off   <= '0;
            wr_entry <= '0;
            unique case (cmd.mode)
              MODE_PUT: begin
                done     <= 1'b1;
                wr_flag  <= 1'b1;
                wr_off   <= cur_off;
                wr_entry <= {text_color, cmd.char_code};
                if (col == LAST_COL) begin
                  col <= '0;
                  if (row == LAST_ROW) begin
                    row      <= '0;
                    row_base <= '0;
                  end else begin
                    row      <= row + ROW_W'(1);
                    row_base <= row_base + ROW_STEP;
                  end
                end else begin
                  col <= col + COL_W'(1);
                end
              end
              MODE_NEWLINE: begin
                done <= 1'b1;
                col  <= '0;
                if (row == LAST_ROW) begin
                  row      <= '0;
                  row_base <= '0;
                end else begin
                  row      <= row + ROW_W'(1);
                  row_base <= row_base + ROW_STEP;
                end
              end
              MODE_BACKSPACE: begin
                if (col != '0) begin
                  done     <= 1'b1;
                  col      <= col - COL_W'(1);
                  wr_flag  <= 1'b1;
                  wr_off   <= cur_off - OFF_W'(1);
                  wr_entry <= blank;
                end else if (row != '0) begin
                  state      <= S_SCAN;
                  row        <= row - ROW_W'(1);
                  row_base   <= row_base - ROW_STEP;
                  scan_col   <= LAST_COL;
                  scan_issue <= 1'b1;
                  rd_pend    <= 1'b0;
                end else begin
                  done <= 1'b1;
                end
              end
              MODE_CLEAR: begin
                state        <= S_SWEEP;
                row          <= '0;
                col          <= '0;
                row_base     <= '0;
                sweep_addr   <= '0;
                sweep_val    <= blank;
                sweep_report <= 1'b1;
              end
            endcase
          end
        end
        S_SCAN: begin
          rd_pend <= scan_issue;
          rd_col  <= scan_col;
          if (scan_issue) begin
            if (scan_col == '0) begin
              scan_issue <= 1'b0;
            end else begin
              scan_col <= scan_col - COL_W'(1);
            end
          end
          if (rd_pend) begin
            if (rd_data != blank) begin
              state      <= S_IDLE;
              done       <= 1'b1;
              scan_issue <= 1'b0;
              rd_pend    <= 1'b0;
              col        <= (rd_col == LAST_COL) ? LAST_COL : rd_col + COL_W'(1);
            end else if (rd_col == '0) begin
              state      <= S_IDLE;
              done       <= 1'b1;
              scan_issue <= 1'b0;
              rd_pend    <= 1'b0;
              col        <= '0;
            end
          end
        end
        S_SWEEP: begin
          if (sweep_addr == LAST_CELL) begin
            state        <= S_IDLE;
            done         <= sweep_report;
            sweep_report <= 1'b0;
          end else begin
            sweep_addr <= sweep_addr + OFF_W'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    result.cursor_row     = row;
    result.cursor_column  = col;
    result.cursor_offset  = cur_off;
    result.wrote_cell     = wr_flag;
    result.written_offset = wr_off;
    result.written_entry  = wr_entry;
  end

  a_row_base: assert property (@(posedge clk) disable iff (rst)
    row_base == OFF_W'(row * COLUMNS))
    else $error("row base out of step with cursor row");

  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) || $past(start))
    else $error("result without a command");

  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.wrote_cell) |-> (result.written_offset == '0 && result.written_entry == '0))
    else $error("write fields set with no cell written");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (scan_col <= LAST_COL && row < LAST_ROW))
    else $error("scan out of range");

endmodule
